// ===== sv/strm_pkg.sv =====
package strm_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;
  localparam int LEN_W  = IDX_W + 1;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_LVL,
    S_Q_LOG,
    S_Q_RD2,
    S_Q_CMP
  } state_t;

endpackage

// ===== sv/strm_ram.sv =====
module strm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/strm_lvl.sv =====
module strm_lvl #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVEL_COUNT  = 11
) (
  input  logic [strm_pkg::LEN_W-1:0]                    len,
  output logic [$clog2(LEVEL_COUNT*MAX_ELEMENTS)-1:0]   base,
  output logic [strm_pkg::LEN_W-1:0]                    span
);

  localparam int AW  = $clog2(LEVEL_COUNT * MAX_ELEMENTS);
  localparam int LW  = strm_pkg::LEN_W;
  localparam int LVW = $clog2(LEVEL_COUNT + 1);

  logic [LVW-1:0] k_raw;
  logic [LVW-1:0] k;

  always_comb begin
    k_raw = '0;
    for (int i = 1; i < LW; i++) begin
      if (len[i]) begin
        k_raw = LVW'(i);
      end
    end
  end

  assign k    = (32'(k_raw) > LEVEL_COUNT - 1) ? LVW'(LEVEL_COUNT - 1) : k_raw;
  assign base = AW'(32'(k) * MAX_ELEMENTS);
  assign span = LW'(1) << k;

endmodule

// ===== sv/sparse_table_range_min.sv =====
// Sparse-table range-minimum engine. Raise start with in_kind and its operands while
// busy is low; the request is taken at that edge. Only an in-range query or an append
// to a table neither empty nor full raises busy, which stays high until the result.
// Each request yields one result, shown for a single cycle with out_valid; there is no
// back-pressure, so out_min_value and out_status must be captured in that cycle. A
// query reads both entries of its level and compares. An append at position p stores
// level 0, then levels 1 to min(floor(log2(p+1)), LEVEL_COUNT-1) one level a cycle via
// the level store's single read port. The store needs no clearing after reset or clear.
module sparse_table_range_min #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVEL_COUNT  = 11,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [strm_pkg::DATA_W-1:0]  in_value,
  input  logic [strm_pkg::IDX_W-1:0]   in_left_index,
  input  logic [strm_pkg::IDX_W-1:0]   in_right_index,
  output logic                         out_valid,
  output logic [strm_pkg::DATA_W-1:0]  out_min_value,
  output logic [1:0]                   out_status
);

  localparam int DW    = strm_pkg::DATA_W;
  localparam int IW    = strm_pkg::IDX_W;
  localparam int LW    = strm_pkg::LEN_W;
  localparam int DEPTH = LEVEL_COUNT * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int PW    = $clog2(MAX_ELEMENTS);
  localparam int LVW   = $clog2(LEVEL_COUNT + 1);
  localparam int EW    = CW + 3;

  strm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]          count_r, count_nxt;
  logic [PW-1:0]          p_r, p_nxt;
  logic [IW-1:0]          lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LVW-1:0]         lvl_r, lvl_nxt;
  logic [CW-1:0]          half_r, half_nxt;
  logic [AW-1:0]          base_r, base_nxt;
  logic [AW-1:0]          addr_b_r, addr_b_nxt;
  logic [VALUE_WIDTH-1:0] cur_r, cur_nxt;
  logic [VALUE_WIDTH-1:0] a_r, a_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [DW-1:0]          out_min_r, out_min_nxt;
  logic [1:0]             out_status_r, out_status_nxt;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [IW-1:0]          in_lo, in_hi;
  logic [LW-1:0]          q_len;
  logic [AW-1:0]          q_base;
  logic [LW-1:0]          q_span;
  logic [AW-1:0]          lvl_base;
  logic [VALUE_WIDTH-1:0] app_min, q_min;
  logic                   next_lvl;
  logic                   accept;

  strm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  strm_lvl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVEL_COUNT  (LEVEL_COUNT)
  ) u_lvl (
    .len  (q_len),
    .base (q_base),
    .span (q_span)
  );

  assign accept   = start && (state_r == strm_pkg::S_IDLE);
  assign in_lo    = (in_left_index < in_right_index) ? in_left_index : in_right_index;
  assign in_hi    = (in_left_index < in_right_index) ? in_right_index : in_left_index;
  assign q_len    = LW'(hi_r) - LW'(lo_r) + LW'(1);
  assign lvl_base = AW'(32'(base_r) + MAX_ELEMENTS);
  assign app_min  = (ram_rdata < cur_r) ? ram_rdata : cur_r;
  assign q_min    = (ram_rdata < a_r) ? ram_rdata : a_r;
  assign next_lvl = (32'(lvl_r) + 1 < LEVEL_COUNT) &&
                    ((EW'(half_r) << 2) <= EW'(p_r) + EW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= strm_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    lvl_r        <= lvl_nxt;
    half_r       <= half_nxt;
    base_r       <= base_nxt;
    addr_b_r     <= addr_b_nxt;
    cur_r        <= cur_nxt;
    a_r          <= a_nxt;
    out_min_r    <= out_min_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    p_nxt          = p_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    lvl_nxt        = lvl_r;
    half_nxt       = half_r;
    base_nxt       = base_r;
    addr_b_nxt     = addr_b_r;
    cur_nxt        = cur_r;
    a_nxt          = a_r;
    out_valid_nxt  = 1'b0;
    out_min_nxt    = out_min_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = cur_r;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state_r)
      strm_pkg::S_IDLE: begin
        if (accept) begin
          out_min_nxt    = '0;
          out_status_nxt = strm_pkg::ST_OK;
          case (in_kind)
            strm_pkg::KIND_APPEND: begin
              if (count_r == CW'(MAX_ELEMENTS)) begin
                out_status_nxt = strm_pkg::ST_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                // store level 0 and fetch the left half for level 1
                ram_we    = 1'b1;
                ram_waddr = AW'(count_r);
                ram_wdata = VALUE_WIDTH'(in_value);
                ram_raddr = AW'(count_r) - AW'(1);
                cur_nxt   = VALUE_WIDTH'(in_value);
                p_nxt     = PW'(count_r);
                lvl_nxt   = LVW'(1);
                half_nxt  = CW'(1);
                base_nxt  = '0;
                count_nxt = count_r + CW'(1);
                if (count_r != '0) begin
                  ram_re    = 1'b1;
                  state_nxt = strm_pkg::S_APP_LVL;
                end else begin
                  out_valid_nxt = 1'b1;
                end
              end
            end
            strm_pkg::KIND_QUERY: begin
              if (EW'(in_hi) >= EW'(count_r)) begin
                out_status_nxt = strm_pkg::ST_RANGE;
                out_valid_nxt  = 1'b1;
              end else begin
                lo_nxt    = in_lo;
                hi_nxt    = in_hi;
                state_nxt = strm_pkg::S_Q_LOG;
              end
            end
            strm_pkg::KIND_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      strm_pkg::S_APP_LVL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(32'(lvl_base) + 32'(p_r));
        ram_wdata = app_min;
        cur_nxt   = app_min;
        if (next_lvl) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(32'(lvl_base) + 32'(p_r) - (32'(half_r) << 1));
          lvl_nxt   = lvl_r + LVW'(1);
          half_nxt  = half_r << 1;
          base_nxt  = lvl_base;
        end else begin
          out_min_nxt    = '0;
          out_status_nxt = strm_pkg::ST_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = strm_pkg::S_IDLE;
        end
      end
      strm_pkg::S_Q_LOG: begin
        ram_re     = 1'b1;
        ram_raddr  = AW'(32'(q_base) + 32'(hi_r));
        addr_b_nxt = AW'(32'(q_base) + 32'(lo_r) + 32'(q_span) - 1);
        state_nxt  = strm_pkg::S_Q_RD2;
      end
      strm_pkg::S_Q_RD2: begin
        ram_re    = 1'b1;
        ram_raddr = addr_b_r;
        a_nxt     = ram_rdata;
        state_nxt = strm_pkg::S_Q_CMP;
      end
      strm_pkg::S_Q_CMP: begin
        out_min_nxt    = DW'(q_min);
        out_status_nxt = strm_pkg::ST_OK;
        out_valid_nxt  = 1'b1;
        state_nxt      = strm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = strm_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != strm_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_status    = out_status_r;

`ifndef ASSERT_OFF
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == strm_pkg::S_IDLE)
    else $error("result strobed while a request is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_ELEMENTS)
    else $error("element count beyond table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind == strm_pkg::KIND_CLEAR |=>
      out_valid_r && count_r == '0 && out_status_r == strm_pkg::ST_OK)
    else $error("clear did not empty the table at once");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != strm_pkg::ST_OK |-> out_min_r == '0)
    else $error("error result carries a non-zero minimum");

  a_query_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == strm_pkg::S_Q_LOG |-> lo_r <= hi_r && EW'(hi_r) < EW'(count_r))
    else $error("query span out of order or beyond stored count");
`endif

endmodule
